// File: rtl/tsft_pkg.sv
// Shared types and constants for the TCP session flow table.
`default_nettype none
package tsft_pkg;

   localparam logic [15:0] ETH_IPV4 = 16'h0800;
   localparam logic [15:0] ETH_VLAN = 16'h8100;
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] FLAGS_OPEN = 8'd18;
   localparam logic [7:0] FLAGS_CLOSE = 8'd17;
   localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

   typedef enum logic [2:0] {
      OUT_IGNORED = 3'd0,
      OUT_OPENED  = 3'd1,
      OUT_DATA    = 3'd2,
      OUT_CLOSED  = 3'd3,
      OUT_NOMATCH = 3'd4,
      OUT_FULL    = 3'd5
   } outcome_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_TIME,
      ST_SCAN,
      ST_CHECK,
      ST_UPDATE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        capture;
      logic        time_mul;
      logic        time_add;
      logic        scan_clear;
      logic        scan_inc;
      logic        open_write;
      logic        update_write;
      logic        emit;
      outcome_type outcome;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_tcp;
      logic is_open;
      logic is_close;
      logic full;
      logic empty;
      logic key_hit;
      logic scan_last;
   } status_type;

endpackage
`default_nettype wire

// File: rtl/tcp_session_flow_table.sv
// Top level of the TCP session flow table.
//
//   channel   ports                      handshake
//   request   start, busy, req_*         taken at an edge with start high and busy low
//   result    rsp_valid, rsp_*           one-cycle strobe, cannot be held off
//
// After the accepting edge busy stays high through ST_MUL and ST_TIME when the packet is
// ignored or the table is empty, and through ST_UPDATE as well when opening; a lookup adds
// one ST_SCAN and ST_CHECK pair per entry compared, then ST_UPDATE on a hit.
// The lookup walks the key memory one entry at a time through its single read port.
// The result appears in the cycle after the item's last step, when busy is already low.
// Reset empties the table at once by clearing the entry count; no clearing pass is run.
`default_nettype none
module tcp_session_flow_table
   import tsft_pkg::*;
#(
   parameter int FLOW_ENTRIES = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [15:0] req_ether_kind,
   input  wire logic [7:0]  req_ip_proto,
   input  wire logic [7:0]  req_tcp_flags,
   input  wire logic [31:0] req_src_addr,
   input  wire logic [31:0] req_dst_addr,
   input  wire logic [15:0] req_src_port,
   input  wire logic [15:0] req_dst_port,
   input  wire logic [15:0] req_ip_length,
   input  wire logic [3:0]  req_ip_hdr_words,
   input  wire logic [3:0]  req_tcp_hdr_words,
   input  wire logic [31:0] req_stamp_sec,
   input  wire logic [19:0] req_stamp_usec,
   output logic             rsp_valid,
   output logic [2:0]       rsp_outcome,
   output logic [6:0]       rsp_entry_index,
   output logic [31:0]      rsp_pkt_total,
   output logic [31:0]      rsp_ip_bytes_total,
   output logic [31:0]      rsp_payload_bytes_total,
   output logic [63:0]      rsp_span_usec
);

   cmd_type    cmd;
   status_type status;

   // Sequencing.
   tsft_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Storage and arithmetic.
   tsft_datapath #(
      .FLOW_ENTRIES (FLOW_ENTRIES)
   ) u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .req_ether_kind          (req_ether_kind),
      .req_ip_proto            (req_ip_proto),
      .req_tcp_flags           (req_tcp_flags),
      .req_src_addr            (req_src_addr),
      .req_dst_addr            (req_dst_addr),
      .req_src_port            (req_src_port),
      .req_dst_port            (req_dst_port),
      .req_ip_length           (req_ip_length),
      .req_ip_hdr_words        (req_ip_hdr_words),
      .req_tcp_hdr_words       (req_tcp_hdr_words),
      .req_stamp_sec           (req_stamp_sec),
      .req_stamp_usec          (req_stamp_usec),
      .rsp_valid               (rsp_valid),
      .rsp_outcome             (rsp_outcome),
      .rsp_entry_index         (rsp_entry_index),
      .rsp_pkt_total           (rsp_pkt_total),
      .rsp_ip_bytes_total      (rsp_ip_bytes_total),
      .rsp_payload_bytes_total (rsp_payload_bytes_total),
      .rsp_span_usec           (rsp_span_usec)
   );

`ifndef SYNTHESIS
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than a cycle");
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("result without an item");
   a_outcome_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_outcome != 3'd6 && rsp_outcome != 3'd7))
      else $error("undefined outcome code");
`endif

endmodule
`default_nettype wire

// File: rtl/tsft_datapath.sv
// Datapath: request registers, timestamp arithmetic, session memories and result registers.
`default_nettype none
module tsft_datapath
   import tsft_pkg::*;
#(
   parameter int FLOW_ENTRIES = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output status_type       status,
   input  wire logic [15:0] req_ether_kind,
   input  wire logic [7:0]  req_ip_proto,
   input  wire logic [7:0]  req_tcp_flags,
   input  wire logic [31:0] req_src_addr,
   input  wire logic [31:0] req_dst_addr,
   input  wire logic [15:0] req_src_port,
   input  wire logic [15:0] req_dst_port,
   input  wire logic [15:0] req_ip_length,
   input  wire logic [3:0]  req_ip_hdr_words,
   input  wire logic [3:0]  req_tcp_hdr_words,
   input  wire logic [31:0] req_stamp_sec,
   input  wire logic [19:0] req_stamp_usec,
   output logic             rsp_valid,
   output logic [2:0]       rsp_outcome,
   output logic [6:0]       rsp_entry_index,
   output logic [31:0]      rsp_pkt_total,
   output logic [31:0]      rsp_ip_bytes_total,
   output logic [31:0]      rsp_payload_bytes_total,
   output logic [63:0]      rsp_span_usec
);

   localparam int IDX_W = $clog2(FLOW_ENTRIES);
   localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);

   // Captured request word.
   logic [15:0] ether_ff;
   logic [7:0]  proto_ff;
   logic [7:0]  flags_ff;
   logic [95:0] key_ff;
   logic [15:0] len_ff;
   logic [3:0]  ihl_ff;
   logic [3:0]  thl_ff;
   logic [31:0] sec_ff;
   logic [19:0] usec_ff;

   logic [51:0] prod_ff;
   logic [63:0] now_ff;
   logic [CNT_W-1:0] count_ff;
   logic [IDX_W-1:0] scan_ff;

   // Session memories.
   logic [95:0] key_mem  [FLOW_ENTRIES];
   logic [31:0] pkt_mem  [FLOW_ENTRIES];
   logic [31:0] ipb_mem  [FLOW_ENTRIES];
   logic [31:0] pay_mem  [FLOW_ENTRIES];
   logic [63:0] open_mem [FLOW_ENTRIES];

   logic [95:0] key_rd_ff;
   logic [31:0] pkt_rd_ff;
   logic [31:0] ipb_rd_ff;
   logic [31:0] pay_rd_ff;
   logic [63:0] open_rd_ff;

   logic [IDX_W-1:0] open_idx;
   logic [IDX_W-1:0] wr_addr;
   logic             wr_en;
   logic [31:0] pkt_in;
   logic [31:0] ipb_in;
   logic [31:0] pay_in;
   logic [6:0]  hdr_bytes;
   logic [15:0] payload;
   logic [63:0] span;

   assign open_idx = IDX_W'(count_ff);
   assign wr_en = cmd.open_write | cmd.update_write;
   assign wr_addr = cmd.open_write ? open_idx : scan_ff;

   // Payload length saturates at zero when the headers exceed the IP length.
   assign hdr_bytes = {(5'(ihl_ff) + 5'(thl_ff)), 2'b00};
   assign payload = (len_ff > 16'(hdr_bytes)) ? (len_ff - 16'(hdr_bytes)) : 16'd0;

   // Values written back on open or on update of a matching entry.
   always_comb begin
      if (cmd.open_write) begin
         pkt_in = 32'd1;
         ipb_in = 32'(len_ff);
         pay_in = 32'd0;
      end else begin
         pkt_in = pkt_rd_ff + 32'd1;
         ipb_in = ipb_rd_ff + 32'(len_ff);
         pay_in = pay_rd_ff + 32'(payload);
      end
   end

   assign span = now_ff - open_rd_ff;

   // Status toward the controller.
   assign status.is_tcp = ((ether_ff == ETH_IPV4) || (ether_ff == ETH_VLAN))
                          && (proto_ff == PROTO_TCP);
   assign status.is_open = (flags_ff == FLAGS_OPEN);
   assign status.is_close = (flags_ff == FLAGS_CLOSE);
   assign status.full = (count_ff == CNT_W'(FLOW_ENTRIES));
   assign status.empty = (count_ff == '0);
   assign status.key_hit = (key_rd_ff == key_ff);
   assign status.scan_last = ((CNT_W'(scan_ff) + CNT_W'(1)) == count_ff);

   // Memory write and registered read at the scan index.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pkt_mem[wr_addr] <= pkt_in;
         ipb_mem[wr_addr] <= ipb_in;
         pay_mem[wr_addr] <= pay_in;
      end
      if (cmd.open_write) begin
         key_mem[wr_addr] <= key_ff;
         open_mem[wr_addr] <= now_ff;
      end
      key_rd_ff <= key_mem[scan_ff];
      pkt_rd_ff <= pkt_mem[scan_ff];
      ipb_rd_ff <= ipb_mem[scan_ff];
      pay_rd_ff <= pay_mem[scan_ff];
      open_rd_ff <= open_mem[scan_ff];
   end

   // Request capture and timestamp in microseconds, multiplied into prod_ff and then summed into now_ff.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ether_ff <= req_ether_kind;
         proto_ff <= req_ip_proto;
         flags_ff <= req_tcp_flags;
         key_ff <= {req_src_addr, req_dst_addr, req_src_port, req_dst_port};
         len_ff <= req_ip_length;
         ihl_ff <= req_ip_hdr_words;
         thl_ff <= req_tcp_hdr_words;
         sec_ff <= req_stamp_sec;
         usec_ff <= req_stamp_usec;
      end
      if (cmd.time_mul) begin
         prod_ff <= 52'(sec_ff) * 52'(USEC_PER_SEC);
      end
      if (cmd.time_add) begin
         now_ff <= 64'(prod_ff) + 64'(usec_ff);
      end
   end

   // Entry count and scan pointer.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         scan_ff <= '0;
      end else begin
         if (cmd.open_write) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.scan_clear) begin
            scan_ff <= '0;
         end else if (cmd.scan_inc) begin
            scan_ff <= scan_ff + IDX_W'(1);
         end
      end
   end

   // Result registers; the strobe lasts one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_outcome <= cmd.outcome;
         rsp_entry_index <= 7'd0;
         rsp_pkt_total <= 32'd0;
         rsp_ip_bytes_total <= 32'd0;
         rsp_payload_bytes_total <= 32'd0;
         rsp_span_usec <= 64'd0;
         if (cmd.outcome == OUT_OPENED) begin
            rsp_entry_index <= 7'(open_idx);
            rsp_pkt_total <= 32'd1;
            rsp_ip_bytes_total <= 32'(len_ff);
         end else if ((cmd.outcome == OUT_DATA) || (cmd.outcome == OUT_CLOSED)) begin
            rsp_entry_index <= 7'(scan_ff);
            rsp_pkt_total <= pkt_in;
            rsp_ip_bytes_total <= ipb_in;
            rsp_payload_bytes_total <= pay_in;
            if (cmd.outcome == OUT_CLOSED) begin
               rsp_span_usec <= span;
            end
         end
      end
   end

`ifndef SYNTHESIS
   a_open_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.open_write |-> !status.full) else $error("open write on full table");
   a_count_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.open_write |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("entry count did not advance");
   a_no_double_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.open_write && cmd.update_write)) else $error("two writes at once");
`endif

endmodule
`default_nettype wire

// File: rtl/tsft_ctrl.sv
// Controller state machine for the TCP session flow table.
`default_nettype none
module tsft_ctrl
   import tsft_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.outcome = OUT_IGNORED;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.time_mul = 1'b1;
            state_in = ST_TIME;
         end
         ST_TIME: begin
            cmd.time_add = 1'b1;
            cmd.scan_clear = 1'b1;
            state_in = ST_IDLE;
            priority if (!status.is_tcp) begin
               cmd.emit = 1'b1;
               cmd.outcome = OUT_IGNORED;
            end else if (status.is_open) begin
               state_in = ST_UPDATE;
            end else if (status.empty) begin
               cmd.emit = 1'b1;
               cmd.outcome = OUT_NOMATCH;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (status.key_hit) begin
               state_in = ST_UPDATE;
            end else if (status.scan_last) begin
               cmd.emit = 1'b1;
               cmd.outcome = OUT_NOMATCH;
               state_in = ST_IDLE;
            end else begin
               cmd.scan_inc = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_UPDATE: begin
            cmd.emit = 1'b1;
            state_in = ST_IDLE;
            priority if (status.is_open) begin
               if (status.full) begin
                  cmd.outcome = OUT_FULL;
               end else begin
                  cmd.open_write = 1'b1;
                  cmd.outcome = OUT_OPENED;
               end
            end else begin
               cmd.update_write = 1'b1;
               cmd.outcome = status.is_close ? OUT_CLOSED : OUT_DATA;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_emit_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (state_ff == ST_IDLE)) else $error("work continued after result");
   a_check_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> ($past(state_ff) == ST_SCAN))
      else $error("compare without a read");
   a_capture_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> !busy) else $error("capture while busy");
`endif

endmodule
`default_nettype wire
